/* sv/i2cm_pkg.sv */
// Shared types and constants for the I2C master register access block.
package i2cm_pkg;

  // Reset value of the seven-bit slave address.
  localparam logic [6:0] DEV_ADDR_RESET = 7'd21;

  // Request selector codes on the input channel.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Classified request kinds passed from the front to the back.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Bus sequencer phases, one-hot.
  typedef enum logic [13:0] {
    PH_IDLE      = 14'h0001,
    PH_START     = 14'h0002,
    PH_ADDR      = 14'h0004,
    PH_ACK_ADDR  = 14'h0008,
    PH_REG       = 14'h0010,
    PH_ACK_REG   = 14'h0020,
    PH_DATA      = 14'h0040,
    PH_ACK_DATA  = 14'h0080,
    PH_STOP      = 14'h0100,
    PH_RSTART    = 14'h0200,
    PH_RADDR     = 14'h0400,
    PH_ACK_RADDR = 14'h0800,
    PH_RECV      = 14'h1000,
    PH_SACK      = 14'h2000
  } phase_t;

  // Input request payload.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic [7:0] read_length;
    logic       sda_in;
  } in_item_t;

  // Result payload.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       nack_seen;
    logic       busy_res;
    logic       command_dropped;
    logic       done_res;
  } out_item_t;

  // Classified request held in the queue.
  typedef struct packed {
    op_t        op;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic [7:0] read_length;
    logic       sda_in;
  } q_item_t;

endpackage

/* sv/i2cm_front.sv */
// Front end: accepts input requests and classifies them for the queue.
module i2cm_front (
  input  i2cm_pkg::in_item_t in_data,
  output i2cm_pkg::q_item_t  q_data
);
  import i2cm_pkg::*;

  op_t op;

  // Decode the selector into a request kind; the unused code does nothing.
  always_comb begin
    case (in_data.func)
      FUNC_TICK:  op = OP_TICK;
      FUNC_WRITE: op = OP_WRITE;
      FUNC_READ:  op = OP_READ;
      default:    op = OP_NONE;
    endcase
  end

  // A zero read length is taken as one byte.
  assign q_data.op          = op;
  assign q_data.reg_address = in_data.reg_address;
  assign q_data.write_data  = in_data.write_data;
  assign q_data.read_length = (in_data.read_length == 8'd0) ? 8'd1 : in_data.read_length;
  assign q_data.sda_in      = in_data.sda_in;

endmodule

/* sv/i2cm_queue.sv */
// Two-entry queue of classified requests between the front and the back.
module i2cm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  i2cm_pkg::q_item_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output i2cm_pkg::q_item_t pop_data
);
  import i2cm_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  q_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != DEPTH[PTR_W:0]);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/i2cm_back.sv */
// Back end: runs the SCL/SDA segment sequencer and holds the result register.
module i2cm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic                q_valid,
  output logic                q_ready,
  input  i2cm_pkg::q_item_t   q_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_item_t out_data
);
  import i2cm_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [7:0] data_r, data_nxt;
  logic       is_read_r, is_read_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic [6:0] dev_r;
  logic       out_valid_r;
  out_item_t  out_r, res;

  logic       enter;
  phase_t     enter_ph;
  logic       f_valid, f_last, f_nack, f_done, dropped;
  logic [7:0] rbyte, rx_shift;
  logic [3:0] bit_inc;
  logic       take;

  assign take      = q_valid && (!out_valid_r || !out_stall);
  assign q_ready   = take;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign bit_inc   = bit_r + 4'd1;
  assign rx_shift  = {shift_r[6:0], q_data.sda_in};

  // Segment sequencer: one request moves the bus by at most one segment.
  always_comb begin
    phase_nxt   = phase_r;
    seg_nxt     = seg_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    reg_nxt     = reg_r;
    data_nxt    = data_r;
    is_read_nxt = is_read_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    enter       = 1'b0;
    enter_ph    = PH_IDLE;
    f_valid     = 1'b0;
    f_last      = 1'b0;
    f_nack      = 1'b0;
    f_done      = 1'b0;
    dropped     = 1'b0;
    rbyte       = 8'd0;

    if (q_data.op == OP_WRITE || q_data.op == OP_READ) begin
      if (phase_r != PH_IDLE) begin
        dropped = 1'b1;
      end else begin
        reg_nxt     = q_data.reg_address;
        data_nxt    = q_data.write_data;
        left_nxt    = q_data.read_length;
        is_read_nxt = (q_data.op == OP_READ);
        enter       = 1'b1;
        enter_ph    = PH_START;
      end
    end else if (q_data.op == OP_TICK && phase_r != PH_IDLE) begin
      case (phase_r)
        PH_START, PH_RSTART: begin
          scl_nxt = 1'b1;
          sda_nxt = (seg_r == 2'd0);
          if (seg_r == 2'd1) begin
            enter    = 1'b1;
            enter_ph = (phase_r == PH_START) ? PH_ADDR : PH_RADDR;
          end else begin
            seg_nxt = seg_r + 2'd1;
          end
        end
        PH_ADDR, PH_REG, PH_DATA, PH_RADDR: begin
          if (seg_r == 2'd0) begin
            scl_nxt = 1'b0;
            seg_nxt = 2'd1;
          end else if (seg_r == 2'd1) begin
            sda_nxt = shift_r[3'd7 - bit_r[2:0]];
            seg_nxt = 2'd2;
          end else begin
            scl_nxt = 1'b1;
            seg_nxt = 2'd0;
            bit_nxt = bit_inc;
            if (bit_inc >= 4'd8) begin
              enter = 1'b1;
              case (phase_r)
                PH_ADDR: enter_ph = PH_ACK_ADDR;
                PH_REG:  enter_ph = PH_ACK_REG;
                PH_DATA: enter_ph = PH_ACK_DATA;
                default: enter_ph = PH_ACK_RADDR;
              endcase
            end
          end
        end
        PH_ACK_ADDR, PH_ACK_REG, PH_ACK_DATA, PH_ACK_RADDR: begin
          sda_nxt = 1'b1;
          scl_nxt = (seg_r == 2'd1) || (seg_r == 2'd2);
          f_nack  = (seg_r == 2'd2) && q_data.sda_in;
          if (seg_r == 2'd3) begin
            enter = 1'b1;
            if (phase_r == PH_ACK_RADDR && left_r == 8'd0) begin
              left_nxt = 8'd1;
            end
            case (phase_r)
              PH_ACK_ADDR: enter_ph = PH_REG;
              PH_ACK_REG:  enter_ph = is_read_r ? PH_RSTART : PH_DATA;
              PH_ACK_DATA: enter_ph = PH_STOP;
              default:     enter_ph = PH_RECV;
            endcase
          end else begin
            seg_nxt = seg_r + 2'd1;
          end
        end
        PH_RECV: begin
          sda_nxt = 1'b1;
          if (seg_r == 2'd0) begin
            scl_nxt = 1'b0;
            seg_nxt = 2'd1;
          end else if (seg_r == 2'd1) begin
            scl_nxt = 1'b1;
            seg_nxt = 2'd2;
          end else begin
            scl_nxt   = 1'b1;
            shift_nxt = rx_shift;
            seg_nxt   = 2'd0;
            bit_nxt   = bit_inc;
            if (bit_inc >= 4'd8) begin
              rbyte    = rx_shift;
              f_valid  = 1'b1;
              f_last   = (left_r <= 8'd1);
              left_nxt = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;
              enter    = 1'b1;
              enter_ph = PH_SACK;
            end
          end
        end
        PH_SACK: begin
          case (seg_r)
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = (left_r == 8'd0);
            2'd2:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
          if (seg_r == 2'd3) begin
            enter    = 1'b1;
            enter_ph = (left_r == 8'd0) ? PH_STOP : PH_RECV;
          end else begin
            seg_nxt = seg_r + 2'd1;
          end
        end
        PH_STOP: begin
          scl_nxt = 1'b1;
          sda_nxt = (seg_r != 2'd0);
          if (seg_r == 2'd0) begin
            seg_nxt = 2'd1;
          end else begin
            enter    = 1'b1;
            enter_ph = PH_IDLE;
            f_done   = 1'b1;
          end
        end
        default: begin
          enter    = 1'b1;
          enter_ph = PH_IDLE;
        end
      endcase
    end

    // Phase entry clears the counters and loads the byte to shift.
    if (enter) begin
      phase_nxt = enter_ph;
      seg_nxt   = 2'd0;
      bit_nxt   = 4'd0;
      case (enter_ph)
        PH_ADDR:  shift_nxt = {dev_r, 1'b0};
        PH_RADDR: shift_nxt = {dev_r, 1'b1};
        PH_REG:   shift_nxt = reg_r;
        PH_DATA:  shift_nxt = data_r;
        PH_RECV:  shift_nxt = 8'd0;
        default:  shift_nxt = shift_nxt;
      endcase
    end
  end

  // Result fields for this request.
  always_comb begin
    res.scl_out         = scl_nxt;
    res.sda_out         = sda_nxt;
    res.read_byte       = rbyte;
    res.read_valid      = f_valid;
    res.read_last       = f_last;
    res.nack_seen       = f_nack;
    res.busy_res        = (phase_nxt != PH_IDLE);
    res.command_dropped = dropped;
    res.done_res        = f_done;
  end

  // Sequencer state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      seg_r     <= 2'd0;
      bit_r     <= 4'd0;
      shift_r   <= 8'd0;
      left_r    <= 8'd0;
      reg_r     <= 8'd0;
      data_r    <= 8'd0;
      is_read_r <= 1'b0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      dev_r     <= DEV_ADDR_RESET;
    end else begin
      if (take) begin
        phase_r   <= phase_nxt;
        seg_r     <= seg_nxt;
        bit_r     <= bit_nxt;
        shift_r   <= shift_nxt;
        left_r    <= left_nxt;
        reg_r     <= reg_nxt;
        data_r    <= data_nxt;
        is_read_r <= is_read_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
      end
      if (cfg_we) begin
        dev_r <= cfg_wdata;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

endmodule

/* sv/i2c_master_register_access.sv */
// Top level of the I2C master for register writes and multi-byte reads.
//
// Usage: each input request carries func, the register address, write data,
// read length and the sampled SDA level. func 1 starts a register write and
// func 2 a register read; both are taken only while the bus is idle, and are
// otherwise reported as dropped. func 0 is a tick that advances the bus by one
// delay segment. Every request yields exactly one result with the SCL/SDA
// levels for that segment, any received byte with its last marker, the NACK,
// busy and done flags.
// The slave address is written through cfg_we/cfg_wdata; the user must write
// it only while idle, as the block itself does not enforce this. A request
// passes through the request queue and then the sequencer's output register
// before its result shows on out_valid. The block takes one request per cycle
// while the receiver does not stall.
// The receiver may stall: the result register holds, the two-entry queue
// fills, and then in_stall rises. After reset the bus is idle with both lines
// released high and the slave address is 21.
module i2c_master_register_access (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_item_t out_data
);
  import i2cm_pkg::*;

  q_item_t front_data;
  q_item_t q_data;
  logic    q_valid;
  logic    push_ready;
  logic    pop_ready;

  assign in_stall = !push_ready;

  // Classify incoming requests.
  i2cm_front u_front (
    .in_data (in_data),
    .q_data  (front_data)
  );

  // Decouple the front from the sequencer.
  i2cm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (push_ready),
    .push_data  (front_data),
    .pop_valid  (q_valid),
    .pop_ready  (pop_ready),
    .pop_data   (q_data)
  );

  // Run the bus sequence and deliver results.
  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (pop_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
